### rtl/htfd_pkg.sv
// Package for the humidity/temperature frame decoder.
// Holds the frame constants, the status codes, the shared frame struct and the CRC-8 step.
// No dependencies.
package htfd_pkg;

  // CRC-8 settings: polynomial x^8 + x^5 + x^4 + 1, preset to all ones.
  localparam logic [7:0] CrcInit = 8'hFF;
  localparam logic [7:0] CrcPoly = 8'h31;

  // Position of the humidity CRC byte, the last byte of a frame.
  localparam logic [2:0] PosLast = 3'd5;

  // Scaling constants, in hundredths, and the full-scale tick count.
  localparam logic [14:0] TempSpan   = 15'd17500;
  localparam logic [15:0] TempOffset = 16'd4500;
  localparam logic [14:0] HumSpan    = 15'd12500;
  localparam logic [14:0] HumOffset  = 15'd600;
  localparam logic [14:0] HumTop     = 15'd10600;
  localparam logic [13:0] HumMax     = 14'd10000;
  localparam logic [16:0] TicksFull  = 17'd65535;

  // Result status codes.
  typedef enum logic [1:0] {
    StatusOk      = 2'd0,
    StatusTempCrc = 2'd1,
    StatusHumCrc  = 2'd2
  } status_e;

  // Frame tracker view, handed to the scaler and the output stage.
  typedef struct packed {
    logic        last_next;   // the next byte without a start flag closes a frame
    logic        done;        // this request closes a frame
    status_e     status;      // CRC verdict of the closing frame
    logic [15:0] temp_ticks;  // stored temperature word
    logic [15:0] hum_ticks;   // stored humidity word
  } frame_t;

  // One byte of CRC-8, MSB first.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### rtl/humidity_temperature_frame_decoder_unit.sv
// Top level of the humidity/temperature frame decoder.
// Depends on htfd_pkg, htfd_frame_ctrl and htfd_scale.
//
// Usage:
// The slave stream carries one frame byte per request: temperature MSB, LSB
// and CRC, then humidity MSB, LSB and CRC. tuser marks the first byte of a
// frame and resynchronizes the tracker; a partial frame is dropped silently.
// After the sixth byte one result request appears on the master stream with
// a status (ok, temperature CRC error, humidity CRC error) and the converted
// temperature and humidity in hundredths; both values are zero on error.
// Latency: the result is valid in the cycle after the sixth byte is taken.
// Throughput: one byte per cycle outside a stall, set by the combinational
// CRC step and the constant-multiply conversion between the state and result
// registers. When the receiver stalls, the result register holds and bytes keep
// being taken until the next one would close a frame; that byte waits for the
// result register to drain.
// Reset clears the byte position, the CRC preset and the result valid flag.
module humidity_temperature_frame_decoder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  logic        s_axis_tuser_i,   // [0] frame_start
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o    // [1:0] status, [16:2] temperature_centi,
                                        // [30:17] humidity_centi, [31] zero
);
  import htfd_pkg::*;

  frame_t             frame;
  logic               s_accept;
  logic               out_free;
  logic signed [14:0] temp_centi;
  logic [13:0]        hum_centi;

  logic               out_valid_q, out_valid_d;
  status_e            status_q, status_d;
  logic signed [14:0] temp_q, temp_d;
  logic [13:0]        hum_q, hum_d;

  // Bytes flow unless the next one closes a frame while a result is stuck.
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = out_free || !frame.last_next;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  htfd_frame_ctrl u_frame_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (s_accept),
    .rx_byte_i     (s_axis_tdata_i),
    .frame_start_i (s_axis_tuser_i),
    .frame_o       (frame)
  );

  htfd_scale u_scale (
    .frame_i             (frame),
    .temperature_centi_o (temp_centi),
    .humidity_centi_o    (hum_centi)
  );

  // Result register load; values are zeroed on a CRC error.
  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready_i;
    status_d    = status_q;
    temp_d      = temp_q;
    hum_d       = hum_q;
    if (frame.done) begin
      out_valid_d = 1'b1;
      status_d    = frame.status;
      temp_d      = (frame.status == StatusOk) ? temp_centi : 15'sd0;
      hum_d       = (frame.status == StatusOk) ? hum_centi : 14'd0;
    end
  end

  // Valid flag with reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    temp_q   <= temp_d;
    hum_q    <= hum_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, hum_q, temp_q, status_q};

  // A frame close always leaves a result in the register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && frame.done) |=> out_valid_q)
    else $error("closed frame produced no result");

  // A frame never closes while an untaken result is held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |-> !frame.done)
    else $error("result overwritten while stalled");

  // Error results carry zero values.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_q != StatusOk)) |-> ((temp_q == 15'sd0) && (hum_q == 14'd0)))
    else $error("error result with nonzero values");

  // Humidity stays clamped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (hum_q <= HumMax))
    else $error("humidity above full scale");

endmodule

### rtl/htfd_frame_ctrl.sv
// Frame tracker: byte position, running CRC and the stored measurement words.
// Depends on htfd_pkg.
module htfd_frame_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  logic [7:0]      rx_byte_i,
  input  logic            frame_start_i,
  output htfd_pkg::frame_t frame_o
);
  import htfd_pkg::*;

  logic [2:0]  pos_q, pos_d, pos_eff;
  logic [7:0]  crc_q, crc_d;
  logic [15:0] temp_ticks_q, temp_ticks_d;
  logic [7:0]  hum_hi_q, hum_hi_d;
  logic [7:0]  hum_lo_q, hum_lo_d;
  logic        temp_ok_q, temp_ok_d;
  logic        done;
  status_e     status;

  // A start flag, or an unused position, restarts the frame at byte 0.
  assign pos_eff = (frame_start_i || (pos_q > PosLast)) ? 3'd0 : pos_q;

  // Next state for one accepted byte.
  always_comb begin
    pos_d        = pos_q;
    crc_d        = crc_q;
    temp_ticks_d = temp_ticks_q;
    hum_hi_d     = hum_hi_q;
    hum_lo_d     = hum_lo_q;
    temp_ok_d    = temp_ok_q;
    done         = 1'b0;
    if (accept_i) begin
      unique case (pos_eff)
        3'd0: begin
          crc_d        = crc8_byte(CrcInit, rx_byte_i);
          temp_ticks_d = {rx_byte_i, 8'h00};
          pos_d        = 3'd1;
        end
        3'd1: begin
          crc_d        = crc8_byte(crc_q, rx_byte_i);
          temp_ticks_d = {temp_ticks_q[15:8], rx_byte_i};
          pos_d        = 3'd2;
        end
        3'd2: begin
          temp_ok_d = (crc_q == rx_byte_i);
          crc_d     = CrcInit;
          pos_d     = 3'd3;
        end
        3'd3: begin
          crc_d    = crc8_byte(CrcInit, rx_byte_i);
          hum_hi_d = rx_byte_i;
          pos_d    = 3'd4;
        end
        3'd4: begin
          crc_d    = crc8_byte(crc_q, rx_byte_i);
          hum_lo_d = rx_byte_i;
          pos_d    = PosLast;
        end
        default: begin
          crc_d = CrcInit;
          pos_d = 3'd0;
          done  = 1'b1;
        end
      endcase
    end
  end

  // The temperature check wins when both words are bad.
  always_comb begin
    priority if (!temp_ok_q) begin
      status = StatusTempCrc;
    end else if (crc_q != rx_byte_i) begin
      status = StatusHumCrc;
    end else begin
      status = StatusOk;
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= 3'd0;
      crc_q        <= CrcInit;
      temp_ticks_q <= 16'h0000;
      hum_hi_q     <= 8'h00;
      hum_lo_q     <= 8'h00;
      temp_ok_q    <= 1'b0;
    end else begin
      pos_q        <= pos_d;
      crc_q        <= crc_d;
      temp_ticks_q <= temp_ticks_d;
      hum_hi_q     <= hum_hi_d;
      hum_lo_q     <= hum_lo_d;
      temp_ok_q    <= temp_ok_d;
    end
  end

  assign frame_o.last_next  = (pos_q == PosLast);
  assign frame_o.done       = done;
  assign frame_o.status     = status;
  assign frame_o.temp_ticks = temp_ticks_q;
  assign frame_o.hum_ticks  = {hum_hi_q, hum_lo_q};

endmodule

### rtl/htfd_scale.sv
// Fixed-point conversion of the stored words to hundredths of a degree and of a percent.
// Depends on htfd_pkg.
module htfd_scale (
  input  htfd_pkg::frame_t   frame_i,
  output logic signed [14:0] temperature_centi_o,
  output logic [13:0]        humidity_centi_o
);
  import htfd_pkg::*;

  logic [30:0] temp_prod, hum_prod;
  logic [14:0] temp_q0, hum_q0, temp_quot, hum_quot;
  logic [16:0] temp_rem, hum_rem;
  logic [15:0] temp_diff;

  // Products by the span constants.
  assign temp_prod = 31'(frame_i.temp_ticks * TempSpan);
  assign hum_prod  = 31'(frame_i.hum_ticks * HumSpan);

  // Division by 65535: the quotient is p >> 16 or one more. The remainder of
  // p >> 16 against 65535 is the low half plus that estimate, below twice 65535.
  assign temp_q0   = temp_prod[30:16];
  assign hum_q0    = hum_prod[30:16];
  assign temp_rem  = {1'b0, temp_prod[15:0]} + {2'b00, temp_q0};
  assign hum_rem   = {1'b0, hum_prod[15:0]} + {2'b00, hum_q0};
  assign temp_quot = temp_q0 + 15'(temp_rem >= TicksFull);
  assign hum_quot  = hum_q0 + 15'(hum_rem >= TicksFull);

  // Temperature offset, two's complement.
  assign temp_diff           = {1'b0, temp_quot} - TempOffset;
  assign temperature_centi_o = $signed(temp_diff[14:0]);

  // Humidity offset with clamping to the 0 to 100 percent range.
  always_comb begin
    priority if (hum_quot < HumOffset) begin
      humidity_centi_o = 14'd0;
    end else if (hum_quot > HumTop) begin
      humidity_centi_o = HumMax;
    end else begin
      humidity_centi_o = 14'(hum_quot - HumOffset);
    end
  end

endmodule
